// ===== hw/rtl/rat_pkg.sv =====
// rotor alignment table builder: shared constants, register indexes and window compare
// no dependencies; compiled before every other file of the block
`default_nettype none

package rat_pkg;

    localparam int TABLE_DEPTH_DEF = 72;
    localparam int ANGLE_BITS_DEF  = 14;

    // field widths
    localparam int FIELD_W     = 14;
    localparam int PHASE_W     = 4;
    localparam int TAG_W       = 6;
    localparam int INDEX_OUT_W = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CMP_W       = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_HIGH = 2'd3;

    // register reset values
    localparam logic [FIELD_W-1:0] CHECK_LOW_RST   = 14'd224;
    localparam logic [FIELD_W-1:0] CHECK_HIGH_RST  = 14'd256;
    localparam logic [FIELD_W-1:0] ACCEPT_LOW_RST  = 14'd223;
    localparam logic [FIELD_W-1:0] ACCEPT_HIGH_RST = 14'd256;

    // tag flag bits
    localparam logic [TAG_W-1:0] TAG_DONE     = 6'h10;
    localparam logic [TAG_W-1:0] TAG_REVERSED = 6'h20;

    typedef logic [CMP_W-1:0] cmp_val_t;

    function automatic logic in_window(input cmp_val_t v, input cmp_val_t lo,
                                       input cmp_val_t hi);
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rat_in_if.sv =====
// input channel of the rotor alignment table builder: valid/ready plus angle and phase id
// depends on rat_pkg for the field widths
`default_nettype none

interface rat_in_if;
    logic                             valid;
    logic                             ready;
    logic [rat_pkg::FIELD_W-1:0]      rotor_angle;
    logic [rat_pkg::PHASE_W-1:0]      phase_id;

    modport source (output valid, output rotor_angle, output phase_id, input ready);
    modport sink   (input valid, input rotor_angle, input phase_id, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rat_out_if.sv =====
// result channel of the rotor alignment table builder: valid/ready plus step result
// depends on rat_pkg for the field widths
`default_nettype none

interface rat_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [rat_pkg::INDEX_OUT_W-1:0]      table_index;
    logic                                 turn_clockwise;
    logic [rat_pkg::FIELD_W-1:0]          measured_delta;
    logic [rat_pkg::TAG_W-1:0]            entry_tag;

    modport source (output valid, output table_index, output turn_clockwise,
                    output measured_delta, output entry_tag, input ready);
    modport sink   (input valid, input table_index, input turn_clockwise,
                    input measured_delta, input entry_tag, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rat_table_mem.sv =====
// entry table: synchronous memory, separate read and write ports, one read and one write a cycle
// valid flags and written flags in flip-flops; depends on nothing else
`default_nettype none

module rat_table_mem #(
    parameter int DEPTH  = 72,
    parameter int WORD_W = 34,
    parameter int IDX_W  = 7
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output logic                   rd_valid,
    output logic [WORD_W-1:0]      rd_word,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire logic [WORD_W-1:0] wr_word,
    input  wire logic              wr_set_valid
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  written_reg;
    logic              rd_valid_reg;
    logic              rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // flags: entries never written read back as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            written_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
                if (wr_set_valid)
                begin
                    valid_reg[wr_addr] <= 1'b1;
                end
            end
            if (rd_en)
            begin
                rd_valid_reg   <= valid_reg[rd_addr];
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_word  = rd_written_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/rat_wrap_dist.sv =====
// wrap-aware angular distance, modulus 2^ANGLE_BITS - 1
// combinational; depends on nothing else
`default_nettype none

module rat_wrap_dist #(
    parameter int ANGLE_BITS = 14
) (
    input  wire logic [ANGLE_BITS-1:0] a1,
    input  wire logic [ANGLE_BITS-1:0] a2,
    output logic      [ANGLE_BITS-1:0] gap
);

    localparam logic [ANGLE_BITS-1:0] ANGLE_MASK = '1;

    logic [ANGLE_BITS-1:0] d1;
    logic [ANGLE_BITS-1:0] d2;

    always_comb
    begin
        if (a1 >= a2)
        begin
            d1 = a1 - a2;
            d2 = (ANGLE_MASK - a1) + a2;
        end
        else
        begin
            d1 = (ANGLE_MASK - a2) + a1;
            d2 = a2 - a1;
        end
        gap = (d1 > d2) ? d2 : d1;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rotor_alignment_table_builder.sv =====
// rotor alignment table builder: top level, sequencer, config registers, result register
// depends on rat_pkg, rat_in_if, rat_out_if, rat_table_mem, rat_wrap_dist
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------------
//  in_ch    | in  | valid / ready  | rotor_angle[13:0], phase_id[3:0]
//  out_ch   | out | valid / ready  | table_index[6:0], turn_clockwise,
//           |     |                | measured_delta[13:0], entry_tag[5:0]
//  cfg      | in  | cfg_we         | cfg_index[1:0], cfg_data[13:0]
//
//  states: read-prev, read-next, exec, write-next if the next entry gets its turn-done
//  flag; the table is read three times (current, previous, next) and written up to twice
//  after reset the table reads as all zero with no clearing pass (flags in flip-flops)
//  a finished result sits in the output register, so a new word is taken while it waits;
//  the write-back stage holds only if the output register is still full
`default_nettype none

module rotor_alignment_table_builder #(
    parameter int TABLE_DEPTH = rat_pkg::TABLE_DEPTH_DEF,
    parameter int ANGLE_BITS  = rat_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    rat_in_if.sink                           in_ch,
    rat_out_if.source                        out_ch,
    input  wire logic                        cfg_we,
    input  wire logic [rat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rat_pkg::FIELD_W-1:0]   cfg_data
);

    import rat_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    // table word: angle | delta | tag
    localparam int DELTA_LSB = TAG_W;
    localparam int ANG_LSB   = TAG_W + FIELD_W;
    localparam int WORD_W    = ANGLE_BITS + FIELD_W + TAG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RD_PREV = 3'd1;
    localparam logic [2:0] ST_RD_NEXT = 3'd2;
    localparam logic [2:0] ST_EXEC    = 3'd3;
    localparam logic [2:0] ST_WR_NEXT = 3'd4;

    logic [2:0] state_reg, state_next;

    // config registers
    logic [FIELD_W-1:0] check_low_reg, check_high_reg, accept_low_reg, accept_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_low_reg   <= CHECK_LOW_RST;
            check_high_reg  <= CHECK_HIGH_RST;
            accept_low_reg  <= ACCEPT_LOW_RST;
            accept_high_reg <= ACCEPT_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHECK_LOW:   check_low_reg   <= cfg_data;
                CFG_CHECK_HIGH:  check_high_reg  <= cfg_data;
                CFG_ACCEPT_LOW:  accept_low_reg  <= cfg_data;
                CFG_ACCEPT_HIGH: accept_high_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // pointer and direction
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             cw_reg, cw_next;
    logic [IDX_W-1:0] up_idx, down_idx, prev_idx, next_idx;

    assign up_idx   = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + IDX_W'(1);
    assign down_idx = (ptr_reg == '0) ? LAST_IDX : ptr_reg - IDX_W'(1);
    assign prev_idx = cw_reg ? down_idx : up_idx;
    assign next_idx = cw_reg ? up_idx : down_idx;

    // word being worked on
    logic [ANGLE_BITS-1:0] angle_reg;
    logic [PHASE_W-1:0]    phase_reg;
    logic [FIELD_W-1:0]    cur_delta_reg;
    logic [TAG_W-1:0]      cur_tag_reg;
    logic                  prev_valid_reg;
    logic [TAG_W-1:0]      prev_tag_reg;
    logic [ANGLE_BITS-1:0] measured_reg;
    logic [IDX_W-1:0]      wr2_addr_reg;
    logic [WORD_W-1:0]     wr2_word_reg;

    // table memory
    logic              mem_rd_en, mem_wr_en, mem_set_valid, mem_rd_valid;
    logic [IDX_W-1:0]  mem_rd_addr, mem_wr_addr;
    logic [WORD_W-1:0] mem_rd_word, mem_wr_word;

    rat_table_mem #(
        .DEPTH  (TABLE_DEPTH),
        .WORD_W (WORD_W),
        .IDX_W  (IDX_W)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_en        (mem_rd_en),
        .rd_addr      (mem_rd_addr),
        .rd_valid     (mem_rd_valid),
        .rd_word      (mem_rd_word),
        .wr_en        (mem_wr_en),
        .wr_addr      (mem_wr_addr),
        .wr_word      (mem_wr_word),
        .wr_set_valid (mem_set_valid)
    );

    logic [ANGLE_BITS-1:0] rd_angle;
    logic [FIELD_W-1:0]    rd_delta;
    logic [TAG_W-1:0]      rd_tag;

    assign rd_angle = mem_rd_word[ANG_LSB +: ANGLE_BITS];
    assign rd_delta = mem_rd_word[DELTA_LSB +: FIELD_W];
    assign rd_tag   = mem_rd_word[0 +: TAG_W];

    // distance from the previous entry's angle, registered before the window test
    logic [ANGLE_BITS-1:0] prev_gap;

    rat_wrap_dist #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dist (
        .a1  (rd_angle),
        .a2  (angle_reg),
        .gap (prev_gap)
    );

    // output register
    logic                   out_valid_reg;
    logic [INDEX_OUT_W-1:0] out_index_reg;
    logic                   out_cw_reg;
    logic [FIELD_W-1:0]     out_delta_reg;
    logic [TAG_W-1:0]       out_tag_reg;
    logic                   out_free;

    assign out_free = !out_valid_reg || out_ch.ready;

    // step decision, evaluated in the exec state with the next entry on the read port
    logic              cur_ok, accept_ok, next_ok;
    logic [WORD_W-1:0] cur_word;
    logic [FIELD_W-1:0] res_delta;
    logic [TAG_W-1:0]  res_tag;
    logic              do_wr_cur, do_wr_next;

    always_comb
    begin
        cur_ok    = in_window(CMP_W'(cur_delta_reg), CMP_W'(check_low_reg),
                              CMP_W'(check_high_reg));
        accept_ok = in_window(CMP_W'(measured_reg), CMP_W'(accept_low_reg),
                              CMP_W'(accept_high_reg));
        next_ok   = in_window(CMP_W'(rd_delta), CMP_W'(check_low_reg),
                              CMP_W'(check_high_reg));
        ptr_next   = ptr_reg;
        cw_next    = cw_reg;
        res_delta  = '0;
        res_tag    = prev_tag_reg;
        do_wr_cur  = 1'b0;
        do_wr_next = 1'b0;
        cur_word   = {angle_reg, cur_delta_reg, TAG_W'(phase_reg)};
        if (cur_ok)
        begin
            // stored delta already correct: turn round, no write
            cw_next  = !cw_reg;
            ptr_next = prev_idx;
        end
        else if (!prev_valid_reg)
        begin
            // nothing to measure against: record the angle and move on
            do_wr_cur = 1'b1;
            ptr_next  = next_idx;
            res_tag   = rd_tag;
        end
        else if (accept_ok)
        begin
            do_wr_cur  = 1'b1;
            cur_word   = {angle_reg, FIELD_W'(measured_reg), TAG_W'(phase_reg)};
            ptr_next   = next_idx;
            res_delta  = FIELD_W'(measured_reg);
            do_wr_next = next_ok;
            res_tag    = next_ok ? (rd_tag | TAG_DONE) : rd_tag;
        end
        else
        begin
            // out of window: mark reversed, turn round
            do_wr_cur = 1'b1;
            cur_word  = {angle_reg, cur_delta_reg, cur_tag_reg | TAG_REVERSED};
            cw_next   = !cw_reg;
            ptr_next  = prev_idx;
            res_delta = FIELD_W'(measured_reg);
        end
    end

    // sequencer and memory port control
    logic in_fire;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next    = state_reg;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = ptr_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = ptr_reg;
        mem_wr_word   = cur_word;
        mem_set_valid = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_RD_PREV;
                end
            end
            ST_RD_PREV:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = prev_idx;
                state_next  = ST_RD_NEXT;
            end
            ST_RD_NEXT:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = next_idx;
                state_next  = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    mem_wr_en  = do_wr_cur;
                    state_next = do_wr_next ? ST_WR_NEXT : ST_IDLE;
                end
            end
            ST_WR_NEXT:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = wr2_addr_reg;
                mem_wr_word   = wr2_word_reg;
                mem_set_valid = 1'b0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    logic exec_fire;

    assign exec_fire = (state_reg == ST_EXEC) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            cw_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                ptr_reg       <= ptr_next;
                cw_reg        <= cw_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    logic [IDX_W+INDEX_OUT_W-1:0] ptr_wide;

    assign ptr_wide = {{INDEX_OUT_W{1'b0}}, ptr_next};

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            angle_reg <= ANGLE_BITS'(in_ch.rotor_angle);
            phase_reg <= in_ch.phase_id;
        end
        if (state_reg == ST_RD_PREV)
        begin
            cur_delta_reg <= rd_delta;
            cur_tag_reg   <= rd_tag;
        end
        if (state_reg == ST_RD_NEXT)
        begin
            prev_valid_reg <= mem_rd_valid;
            prev_tag_reg   <= rd_tag;
            measured_reg   <= prev_gap;
        end
        if (exec_fire)
        begin
            wr2_addr_reg  <= next_idx;
            wr2_word_reg  <= {rd_angle, rd_delta, rd_tag | TAG_DONE};
            out_index_reg <= ptr_wide[INDEX_OUT_W-1:0];
            out_cw_reg    <= cw_next;
            out_delta_reg <= res_delta;
            out_tag_reg   <= res_tag;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.table_index    = out_index_reg;
    assign out_ch.turn_clockwise = out_cw_reg;
    assign out_ch.measured_delta = out_delta_reg;
    assign out_ch.entry_tag      = out_tag_reg;

    // checks
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, ptr_reg} < (IDX_W + 1)'(TABLE_DEPTH))
        else $error("table pointer beyond table depth");

    a_no_rd_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("table read and write in the same cycle");

    a_exec_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> out_valid_reg)
        else $error("result not loaded after step");

    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && !do_wr_next) |=> (state_reg == ST_IDLE))
        else $error("sequencer not idle after step");

endmodule

`default_nettype wire
